### hdl/cbq_pkg.sv
`timescale 1ns / 1ps

package cbq_pkg;

    localparam int NUM_STAGES_DEF = 10;

    // fixed-point scaling
    localparam int WORD_SHIFT  = 16;
    localparam int POST_SHIFT  = 3;
    localparam int EXTRA_SHIFT = 1;
    localparam int ACC_SHIFT   = POST_SHIFT + EXTRA_SHIFT;

    localparam int COEF_PER_STAGE = 5;
    localparam int HIST_PER_STAGE = 8;

    // function codes of an input transaction
    typedef enum logic [1:0] {
        FUNC_PROC  = 2'd0,
        FUNC_WCOEF = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    // coefficient position inside a stage
    localparam logic [2:0] POS_B0 = 3'd0;
    localparam logic [2:0] POS_B1 = 3'd1;
    localparam logic [2:0] POS_B2 = 3'd2;
    localparam logic [2:0] POS_A1 = 3'd3;
    localparam logic [2:0] POS_A2 = 3'd4;

    // history word position inside a stage/channel group
    localparam logic [1:0] HPOS_X1 = 2'd0;
    localparam logic [1:0] HPOS_X2 = 2'd1;
    localparam logic [1:0] HPOS_Y1 = 2'd2;
    localparam logic [1:0] HPOS_Y2 = 2'd3;

    typedef enum logic {
        BSEL_X,
        BSEL_HIST
    } t_bsel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        WSEL_X1,
        WSEL_XW,
        WSEL_Y1,
        WSEL_ACC
    } t_wsel;

    typedef struct packed {
        logic [1:0]          func;
        logic                channel;
        logic signed [15:0]  sample;
        logic [5:0]          coeff_index;
        logic signed [31:0]  coeff_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0]  sample_out;
        logic                channel_out;
    } t_out;

    // one microcode word
    typedef struct packed {
        logic        coef_rd;
        logic [2:0]  coef_pos;
        logic        coef_next;   // read b0 of the following stage
        logic        hist_rd;
        logic [1:0]  hist_rpos;
        logic        mul_en;
        t_bsel       bsel;
        t_acc_op     acc_op;
        logic        cap_x1;
        logic        cap_y1;
        logic        hist_wr;
        logic [1:0]  hist_wpos;
        t_wsel       wsel;
        logic        stage_end;   // conditional jump: next stage or finish
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic   start;
        logic   run;
        logic   last;
        t_uword uw;
    } t_ctrl;

    localparam logic [2:0] STEP_FIRST = 3'd0;
    localparam logic [2:0] STEP_LOOP  = 3'd1;

    function automatic t_uword uc_rom(input logic [2:0] step);
        t_uword w;
        w = '0;
        w.bsel   = BSEL_HIST;
        w.acc_op = ACC_HOLD;
        w.wsel   = WSEL_X1;
        case (step)
            3'd0: begin
                w.coef_rd = 1'b1; w.coef_pos = POS_B0;
            end
            3'd1: begin
                w.coef_rd = 1'b1; w.coef_pos = POS_B1;
                w.hist_rd = 1'b1; w.hist_rpos = HPOS_X1;
                w.mul_en = 1'b1; w.bsel = BSEL_X;
            end
            3'd2: begin
                w.coef_rd = 1'b1; w.coef_pos = POS_B2;
                w.hist_rd = 1'b1; w.hist_rpos = HPOS_X2;
                w.mul_en = 1'b1; w.acc_op = ACC_LOAD;
                w.cap_x1 = 1'b1;
            end
            3'd3: begin
                w.coef_rd = 1'b1; w.coef_pos = POS_A1;
                w.hist_rd = 1'b1; w.hist_rpos = HPOS_Y1;
                w.mul_en = 1'b1; w.acc_op = ACC_ADD;
                w.hist_wr = 1'b1; w.hist_wpos = HPOS_X2; w.wsel = WSEL_X1;
            end
            3'd4: begin
                w.coef_rd = 1'b1; w.coef_pos = POS_A2;
                w.hist_rd = 1'b1; w.hist_rpos = HPOS_Y2;
                w.mul_en = 1'b1; w.acc_op = ACC_ADD;
                w.hist_wr = 1'b1; w.hist_wpos = HPOS_X1; w.wsel = WSEL_XW;
                w.cap_y1 = 1'b1;
            end
            3'd5: begin
                w.mul_en = 1'b1; w.acc_op = ACC_ADD;
                w.hist_wr = 1'b1; w.hist_wpos = HPOS_Y2; w.wsel = WSEL_Y1;
            end
            3'd6: begin
                w.acc_op = ACC_ADD;
            end
            3'd7: begin
                w.hist_wr = 1'b1; w.hist_wpos = HPOS_Y1; w.wsel = WSEL_ACC;
                w.coef_rd = 1'b1; w.coef_pos = POS_B0; w.coef_next = 1'b1;
                w.stage_end = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

### hdl/cascaded_biquad_eq_stereo.sv
`timescale 1ns / 1ps

// Stereo cascaded biquad equalizer, direct form 1, fixed point. Each input
// transaction carries a function code: process a sample (one result
// transaction follows), write a Q28 coefficient (slot = stage*5 + b0,b1,b2,
// a1,a2; feedback terms pre-negated; slots past the table are ignored), or
// clear every filter history. Both channels share the coefficient table and
// keep separate histories. A sample is filtered by a microcoded sequencer
// driving a single 32x32 multiplier and accumulator: a start step, then the
// steps of each stage, so the input stalls while a sample is being filtered
// and the next sample is accepted only once the sequencer is idle again. The
// per-stage steps are set by the one multiplier and the single read port of
// the coefficient and history memories. The last step also waits while a
// previous result is still held in the output register and stalled.

module cascaded_biquad_eq_stereo import cbq_pkg::*; #(
    parameter int NUM_STAGES = NUM_STAGES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int SW = NUM_STAGES > 1 ? $clog2(NUM_STAGES) : 1;

    logic          w_in_acc;
    logic          w_start;
    logic          w_cwr;
    logic          w_clr;
    logic          w_busy;
    logic          w_done;
    logic          w_out_free;
    t_ctrl         w_ctrl;
    logic [SW-1:0] w_stage;
    logic [31:0]   w_y;

    logic          r_chan;
    logic          r_out_valid;
    t_out          r_out;

    // input side: one transaction at a time while the sequencer runs
    assign o_in_stall = w_busy;
    assign w_in_acc   = i_in_valid && !w_busy;

    // function decode on the accepted transaction; the spare code does nothing
    always_comb begin
        w_start = 1'b0;
        w_cwr   = 1'b0;
        w_clr   = 1'b0;
        case (i_in.func)
            FUNC_PROC:  w_start = w_in_acc;
            FUNC_WCOEF: w_cwr   = w_in_acc;
            FUNC_CLEAR: w_clr   = w_in_acc;
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_chan <= i_in.channel;
        end
    end

    // output register frees up in the same cycle it is taken
    assign w_out_free = !r_out_valid || !i_out_stall;

    cbq_seq #(
        .NUM_STAGES (NUM_STAGES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl),
        .o_stage    (w_stage),
        .o_busy     (w_busy),
        .o_done     (w_done)
    );

    cbq_dp #(
        .NUM_STAGES (NUM_STAGES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_stage  (w_stage),
        .i_chan   (r_chan),
        .i_sample (i_in.sample),
        .i_cwr    (w_cwr),
        .i_cidx   (i_in.coeff_index),
        .i_cval   (i_in.coeff_value),
        .i_clr    (w_clr),
        .o_y      (w_y)
    );

    // result register: last stage's scaled accumulator, top half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out.sample_out  <= w_y[31:WORD_SHIFT];
            r_out.channel_out <= r_chan;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (o_out_valid && o_out.channel_out == $past(r_chan)))
        else $error("finished sample did not reach the output register");
`endif

endmodule

### hdl/cbq_seq.sv
`timescale 1ns / 1ps

module cbq_seq import cbq_pkg::*; #(
    parameter int NUM_STAGES = NUM_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_out_free,
    output t_ctrl                                 o_ctrl,
    output logic [(NUM_STAGES > 1 ? $clog2(NUM_STAGES) : 1)-1:0] o_stage,
    output logic                                  o_busy,
    output logic                                  o_done
);

    localparam int SW = NUM_STAGES > 1 ? $clog2(NUM_STAGES) : 1;

    logic          r_busy;
    logic [2:0]    r_step;
    logic [SW-1:0] r_stage;
    t_uword        w_uw;
    logic          w_last;
    logic          w_hold;

    assign w_uw   = uc_rom(r_step);
    assign w_last = (r_stage == SW'(NUM_STAGES - 1));
    // final step waits for the output register to drain
    assign w_hold = r_busy && w_uw.stage_end && w_last && !i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= STEP_FIRST;
            r_stage <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_step  <= STEP_FIRST;
            r_stage <= '0;
        end else if (r_busy && !w_hold) begin
            if (w_uw.stage_end) begin
                if (w_last) begin
                    r_busy  <= 1'b0;
                    r_step  <= STEP_FIRST;
                    r_stage <= '0;
                end else begin
                    r_stage <= r_stage + 1'b1;
                    r_step  <= STEP_LOOP;
                end
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_ctrl.start = i_start;
    assign o_ctrl.run   = r_busy && !w_hold;
    assign o_ctrl.last  = w_last;
    assign o_ctrl.uw    = w_uw;
    assign o_stage      = r_stage;
    assign o_busy       = r_busy;
    assign o_done       = r_busy && w_uw.stage_end && w_last && i_out_free;

`ifndef SYNTH
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_step == STEP_FIRST && r_stage == '0))
        else $error("sequencer idle with step or stage not at origin");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !r_busy)
        else $error("sequencer still busy after finishing");
`endif

endmodule

### hdl/cbq_dp.sv
`timescale 1ns / 1ps

module cbq_dp import cbq_pkg::*; #(
    parameter int NUM_STAGES = NUM_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_ctrl                                 i_ctrl,
    input  logic [(NUM_STAGES > 1 ? $clog2(NUM_STAGES) : 1)-1:0] i_stage,
    input  logic                                  i_chan,
    input  logic signed [15:0]                    i_sample,
    input  logic                                  i_cwr,
    input  logic [5:0]                            i_cidx,
    input  logic signed [31:0]                    i_cval,
    input  logic                                  i_clr,
    output logic [31:0]                           o_y
);

    localparam int SW         = NUM_STAGES > 1 ? $clog2(NUM_STAGES) : 1;
    localparam int COEF_DEPTH = COEF_PER_STAGE * NUM_STAGES;
    localparam int HIST_DEPTH = HIST_PER_STAGE * NUM_STAGES;
    localparam int CAW        = $clog2(COEF_DEPTH);
    localparam int HAW        = SW + 3;

    logic [31:0]           r_cmem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0] r_cvalid;
    logic [31:0]           r_hmem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_hvalid;

    logic [CAW-1:0] r_cbase;
    logic [31:0]    r_crd;
    logic           r_crd_v;
    logic [31:0]    r_hrd;
    logic           r_hrd_v;
    logic [31:0]    r_xw;
    logic [31:0]    r_x1;
    logic [31:0]    r_y1;
    logic [31:0]    r_phi;
    logic [31:0]    r_acc;

    logic               w_cwe;
    logic [CAW-1:0]     w_cwa;
    logic               w_cre;
    logic [CAW-1:0]     w_cra;
    logic               w_hre;
    logic               w_hwe;
    logic [HAW-1:0]     w_hra;
    logic [HAW-1:0]     w_hwa;
    logic [31:0]        w_hwd;
    logic [31:0]        w_hist;
    logic [31:0]        w_a;
    logic [31:0]        w_b;
    logic signed [63:0] w_prod;
    logic [31:0]        w_y;
    t_uword             w_uw;

    assign w_uw = i_ctrl.uw;

    // coefficient port: writes only while idle, writes past the table dropped
    assign w_cwe = i_cwr && (32'(i_cidx) < COEF_DEPTH);
    assign w_cwa = CAW'(i_cidx);
    assign w_cre = i_ctrl.run && w_uw.coef_rd && !(w_uw.coef_next && i_ctrl.last);
    assign w_cra = r_cbase + (w_uw.coef_next ? CAW'(COEF_PER_STAGE) : CAW'(w_uw.coef_pos));

    always_ff @(posedge i_clk) begin
        if (w_cwe) begin
            r_cmem[w_cwa] <= i_cval;
        end
        if (w_cre) begin
            r_crd <= r_cmem[w_cra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_crd_v  <= 1'b0;
        end else begin
            if (w_cwe) begin
                r_cvalid[w_cwa] <= 1'b1;
            end
            if (w_cre) begin
                r_crd_v <= r_cvalid[w_cra];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_cbase <= '0;
        end else if (i_ctrl.run && w_uw.stage_end) begin
            r_cbase <= r_cbase + CAW'(COEF_PER_STAGE);
        end
    end

    // history memory: {stage, channel, word}
    assign w_hre = i_ctrl.run && w_uw.hist_rd;
    assign w_hwe = i_ctrl.run && w_uw.hist_wr;
    assign w_hra = {i_stage, i_chan, w_uw.hist_rpos};
    assign w_hwa = {i_stage, i_chan, w_uw.hist_wpos};

    always_comb begin
        case (w_uw.wsel)
            WSEL_X1:  w_hwd = r_x1;
            WSEL_XW:  w_hwd = r_xw;
            WSEL_Y1:  w_hwd = r_y1;
            WSEL_ACC: w_hwd = w_y;
            default:  w_hwd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_hmem[w_hwa] <= w_hwd;
        end
        if (w_hre) begin
            r_hrd <= r_hmem[w_hra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
            r_hrd_v  <= 1'b0;
        end else begin
            if (i_clr) begin
                r_hvalid <= '0;
            end else if (w_hwe) begin
                r_hvalid[w_hwa] <= 1'b1;
            end
            if (w_hre) begin
                r_hrd_v <= r_hvalid[w_hra];
            end
        end
    end

    assign w_hist = r_hrd_v ? r_hrd : 32'd0;

    // shared multiplier, high word registered
    assign w_a    = r_crd_v ? r_crd : 32'd0;
    assign w_b    = (w_uw.bsel == BSEL_X) ? r_xw : w_hist;
    assign w_prod = $signed(w_a) * $signed(w_b);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.run && w_uw.mul_en) begin
            r_phi <= w_prod[63:32];
        end
        if (i_ctrl.run) begin
            case (w_uw.acc_op)
                ACC_LOAD: r_acc <= r_phi;
                ACC_ADD:  r_acc <= r_acc + r_phi;
                default:  r_acc <= r_acc;
            endcase
        end
        if (i_ctrl.run && w_uw.cap_x1) begin
            r_x1 <= w_hist;
        end
        if (i_ctrl.run && w_uw.cap_y1) begin
            r_y1 <= w_hist;
        end
        if (i_ctrl.start) begin
            r_xw <= {i_sample, 16'd0};
        end else if (i_ctrl.run && w_uw.stage_end) begin
            r_xw <= {w_y[31:WORD_SHIFT], 16'd0};
        end
    end

    assign w_y = r_acc << ACC_SHIFT;
    assign o_y = w_y;

`ifndef SYNTH
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hwe && w_hre) |-> (w_uw.hist_wpos != w_uw.hist_rpos))
        else $error("history read and write hit the same word");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cwr || i_clr) |-> !i_ctrl.run)
        else $error("coefficient write or clear while filtering");
`endif

endmodule
